[src/keyed_wavetable_voice_synth_top_assert.svh]
// Assertion macros shared by the voice synth RTL.
// Included by kwvs_div.sv and keyed_wavetable_voice_synth_top.sv; expects aclk and aresetn.
`ifndef KEYED_WAVETABLE_VOICE_SYNTH_TOP_ASSERT_SVH
`define KEYED_WAVETABLE_VOICE_SYNTH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define KWVS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define KWVS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KWVS_ASSERT_IMP(label, ante, cons, msg)
`define KWVS_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[src/kwvs_pkg.sv]
// Package for the keyed wavetable voice synth: sizes, reset values, wave tables,
// and the request/response types of the shared divider. No dependencies.
`timescale 1ns / 1ps

package kwvs_pkg;

    // Configuration of the voice and key counts
    localparam int NUM_VOICES = 3;
    localparam int NUM_KEYS   = 5;
    localparam int WAVE_COUNT = 5;
    localparam int KEY_FIELDS = 5;
    localparam int OUT_SLOTS  = 3;
    localparam int KEY_CNT    = (NUM_KEYS < WAVE_COUNT) ? NUM_KEYS : WAVE_COUNT;

    // Field widths
    localparam int LEVEL_W = 8;
    localparam int VOL_W   = 5;
    localparam int POS_W   = 5;
    localparam int NOTE_W  = 3;
    localparam int SMP_W   = 4;
    localparam int THR_W   = 5;
    localparam int EN_W    = 3;
    localparam int ROM_AW  = 7;

    // Stream and bus widths
    localparam int S_TDATA_W = LEVEL_W * (KEY_FIELDS + 1);
    localparam int M_FIELD_W = OUT_SLOTS * SMP_W + EN_W + LEVEL_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Reset values and scaling constants
    localparam logic [NOTE_W-1:0]  NO_NOTE       = 3'd5;
    localparam logic [THR_W-1:0]   THR_RESET     = 5'd8;
    localparam logic [LEVEL_W-1:0] CAL_MAX_RESET = 8'd200;
    localparam logic [LEVEL_W-1:0] CAL_MIN_RESET = 8'd60;
    localparam logic [LEVEL_W-1:0] PERIOD_RESET  = 8'd250;
    localparam logic [LEVEL_W-1:0] PERIOD_OFFSET = 8'd125;

    // Shared divider sizing
    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = 8;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Five waves stored back to back
    localparam logic [SMP_W-1:0] WAVE_ROM [0:118] = '{
        4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5,
        4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13, 4'd14, 4'd14, 4'd14, 4'd14,
        4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6,
        4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11,
        4'd12, 4'd12, 4'd13, 4'd13, 4'd14, 4'd14, 4'd15,
        4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd6,
        4'd7, 4'd7, 4'd8, 4'd9, 4'd9, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12,
        4'd13, 4'd14, 4'd14, 4'd15,
        4'd1, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd6, 4'd7, 4'd8,
        4'd9, 4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };
    localparam logic [ROM_AW-1:0] WAVE_BASE [0:WAVE_COUNT-1] =
        '{7'd0, 7'd30, 7'd57, 7'd81, 7'd101};
    localparam logic [POS_W-1:0] WAVE_LEN [0:WAVE_COUNT-1] =
        '{5'd30, 5'd27, 5'd24, 5'd20, 5'd18};

    // Divider handshake
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

[src/kwvs_div.sv]
// Restoring divider, one quotient bit per cycle; a zero divisor yields quotient 0.
// Depends on kwvs_pkg and keyed_wavetable_voice_synth_top_assert.svh.
`timescale 1ns / 1ps

module kwvs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  kwvs_pkg::div_req_t req,
    output kwvs_pkg::div_rsp_t rsp
);
    import kwvs_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  zero_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVISOR_W:0]    rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;

    // One shift-subtract step
    assign rem_shift = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    // Control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
        end else if (busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (req.start) begin
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg  <= req.divisor;
            zero_reg <= (req.divisor == '0);
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
        end else if (busy_reg) begin
            rem_reg  <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            quo_reg  <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = zero_reg ? '0 : quo_reg;

    `include "keyed_wavetable_voice_synth_top_assert.svh"

    `KWVS_ASSERT_IMP(a_start_when_idle, req.start, !busy_reg, "divider started while busy")
    `KWVS_ASSERT_NXT(a_start_goes_busy, req.start, busy_reg, "divider did not go busy")
    `KWVS_ASSERT_NXT(a_done_single, done_reg, !done_reg && !busy_reg, "divider done not a pulse")

endmodule

[src/keyed_wavetable_voice_synth_top.sv]
// Top level of the keyed wavetable voice synth: sequencer, voice and calibration state.
// Depends on kwvs_pkg, kwvs_div and keyed_wavetable_voice_synth_top_assert.svh.
`timescale 1ns / 1ps

// Usage:
//  Input stream s_*: s_tuser is the opcode (1 = key scan, 0 = sample tick); s_tdata carries
//  the pitch level and five key levels. Every transaction gives exactly one result on m_*:
//  three 4-bit voice levels, the voice enable bits and the sample period.
//  A tick steps the three voices one per cycle, then its result is registered in the
//  output register. A scan runs six divisions (pitch, then one per key) on the shared
//  restoring divider, one after another, and then its result is registered. The divider's
//  one bit per cycle sets the scan time.
//  s_tready is high only while the sequencer is idle; one item is handled at a time, so
//  the next item is taken only after the last one's result has been loaded for output.
//  If the output register still holds an untaken result when a new one is done, the
//  sequencer waits until it frees up; a result stays on m_tdata until taken.
//  The APB port holds active_threshold at address 0 (reset 8); write it only while idle.
//  Synchronous active-low reset restores the calibration (60..200), period 250, clears all
//  voices, drops m_tvalid and returns the sequencer to idle.
module keyed_wavetable_voice_synth_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kwvs_pkg::APB_AW-1:0]    paddr,
    input  logic [kwvs_pkg::APB_DW-1:0]    pwdata,
    output logic [kwvs_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] pitch_level, [15:8] key_level_0 ... [47:40] key_level_4
    input  logic [kwvs_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic [0:0]                     s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] level_a, [7:4] level_b, [11:8] level_c, [14:12] voice_enable,
    // [22:15] sample_period, [23] zero
    output logic [kwvs_pkg::M_TDATA_W-1:0] m_tdata
);
    import kwvs_pkg::*;

    localparam int STEP_W  = $clog2(KEY_CNT + 1);
    localparam int KEY_W   = (KEY_CNT > 1) ? $clog2(KEY_CNT) : 1;
    localparam int USED_W  = $clog2(NUM_VOICES + 1);
    localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic OP_SCAN       = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_START   = 6'b000010,
        ST_WAIT    = 6'b000100,
        ST_SILENCE = 6'b001000,
        ST_TICK    = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg;
    logic [USED_W-1:0]      vsel_reg;
    logic [LEVEL_W-1:0]     pitch_reg;
    logic [LEVEL_W-1:0]     lvl_reg     [KEY_FIELDS];
    logic [THR_W-1:0]       thr_reg;
    logic [LEVEL_W-1:0]     cal_max_reg [KEY_CNT];
    logic [LEVEL_W-1:0]     cal_min_reg [KEY_CNT];
    logic [NOTE_W-1:0]      note_reg    [NUM_VOICES];
    logic [POS_W-1:0]       pos_reg     [NUM_VOICES];
    logic [VOL_W-1:0]       vol_reg     [NUM_VOICES];
    logic [NUM_VOICES-1:0]  on_reg;
    logic [SMP_W-1:0]       last_reg    [NUM_VOICES];
    logic [LEVEL_W-1:0]     period_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   out_load;
    logic [KEY_W-1:0]       key_idx;
    logic [VOICE_W-1:0]     vidx;
    logic                   is_pitch;
    logic                   last_key;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_THRESHOLD) ? APB_DW'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_write && (paddr[2] == REG_THRESHOLD)) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // Handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign key_idx  = KEY_W'(step_reg - STEP_W'(1));
    assign vidx     = vsel_reg[VOICE_W-1:0];
    assign is_pitch = (step_reg == '0);
    assign last_key = (step_reg == STEP_W'(KEY_CNT));

    // Divider operands: pitch with key 0's old calibration, or a key after widening
    logic [LEVEL_W-1:0]    p_clamp, p_off, p_span;
    logic [LEVEL_W-1:0]    k_lv, k_max, k_min, k_off, k_span;
    always_comb begin
        p_clamp = pitch_reg;
        if (p_clamp < cal_min_reg[0]) p_clamp = cal_min_reg[0];
        if (p_clamp > cal_max_reg[0]) p_clamp = cal_max_reg[0];
        p_off  = p_clamp - cal_min_reg[0];
        p_span = cal_max_reg[0] - cal_min_reg[0];
        k_lv   = lvl_reg[key_idx];
        k_max  = (cal_max_reg[key_idx] < k_lv) ? k_lv : cal_max_reg[key_idx];
        k_min  = (cal_min_reg[key_idx] > k_lv) ? k_lv : cal_min_reg[key_idx];
        k_off  = k_lv - k_min;
        k_span = k_max - k_min;
    end

    // off*255 as (off<<8)-off, off*16 as a shift
    assign div_req.start    = (state_reg == ST_START);
    assign div_req.dividend = is_pitch ? ({p_off, 8'd0} - DIVIDEND_W'(p_off))
                                       : DIVIDEND_W'({k_off, 4'd0});
    assign div_req.divisor  = is_pitch ? p_span : k_span;

    kwvs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic [VOL_W-1:0] q_vol;
    logic             claim;
    assign q_vol = div_rsp.quotient[VOL_W-1:0];
    assign claim = (q_vol > thr_reg) && (vsel_reg < USED_W'(NUM_VOICES));

    // Tick path for the selected voice
    logic [NOTE_W-1:0]       t_note;
    logic                    t_active;
    logic [$clog2(WAVE_COUNT)-1:0] t_wave;
    logic [POS_W:0]          t_inc;
    logic [POS_W-1:0]        t_pos;
    logic [ROM_AW-1:0]       t_addr;
    logic [SMP_W+VOL_W-1:0]  t_prod;
    logic [SMP_W-1:0]        t_level;
    always_comb begin
        t_note   = note_reg[vidx];
        t_active = (vol_reg[vidx] != '0) && (t_note < NOTE_W'(WAVE_COUNT));
        t_wave   = t_active ? t_note[$clog2(WAVE_COUNT)-1:0] : '0;
        t_inc    = {1'b0, pos_reg[vidx]} + 1'b1;
        t_pos    = (t_inc >= {1'b0, WAVE_LEN[t_wave]}) ? '0 : t_inc[POS_W-1:0];
        t_addr   = WAVE_BASE[t_wave] + ROM_AW'(t_pos);
        t_prod   = (SMP_W+VOL_W)'(WAVE_ROM[t_addr]) * (SMP_W+VOL_W)'(vol_reg[vidx]);
        t_level  = t_active ? t_prod[SMP_W+VOL_W-2:SMP_W] : '0;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) state_next = (s_tuser[0] == OP_SCAN) ? ST_START : ST_TICK;
            end
            ST_START: state_next = ST_WAIT;
            ST_WAIT: begin
                if (div_rsp.done) state_next = last_key ? ST_SILENCE : ST_START;
            end
            ST_SILENCE: state_next = ST_FINISH;
            ST_TICK: begin
                if (vidx == VOICE_W'(NUM_VOICES - 1)) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            vsel_reg   <= '0;
            period_reg <= PERIOD_RESET;
            on_reg     <= '0;
            for (int k = 0; k < KEY_CNT; k++) begin
                cal_max_reg[k] <= CAL_MAX_RESET;
                cal_min_reg[k] <= CAL_MIN_RESET;
            end
            for (int v = 0; v < NUM_VOICES; v++) begin
                note_reg[v] <= NO_NOTE;
                pos_reg[v]  <= '0;
                vol_reg[v]  <= '0;
                last_reg[v] <= '0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    vsel_reg <= '0;
                end
                ST_START: begin
                    // key widens its calibration as its division starts
                    if (!is_pitch) begin
                        cal_max_reg[key_idx] <= k_max;
                        cal_min_reg[key_idx] <= k_min;
                    end
                end
                ST_WAIT: begin
                    if (div_rsp.done) begin
                        if (is_pitch) begin
                            period_reg <= div_rsp.quotient[LEVEL_W-1:0] + PERIOD_OFFSET;
                        end else if (claim) begin
                            if (note_reg[vidx] != NOTE_W'(key_idx)) begin
                                note_reg[vidx] <= NOTE_W'(key_idx);
                                pos_reg[vidx]  <= '0;
                            end
                            vol_reg[vidx] <= q_vol;
                            on_reg[vidx]  <= 1'b1;
                            vsel_reg      <= vsel_reg + 1'b1;
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SILENCE: begin
                    // voices beyond the claimed ones go quiet
                    for (int v = 0; v < NUM_VOICES; v++) begin
                        if (USED_W'(v) >= vsel_reg) begin
                            on_reg[v]  <= 1'b0;
                            vol_reg[v] <= '0;
                        end
                    end
                end
                ST_TICK: begin
                    if (t_active) pos_reg[vidx] <= t_pos;
                    last_reg[vidx] <= t_level;
                    vsel_reg       <= vsel_reg + 1'b1;
                end
                ST_FINISH: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Input capture
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pitch_reg <= s_tdata[LEVEL_W-1:0];
            for (int k = 0; k < KEY_FIELDS; k++) begin
                lvl_reg[k] <= s_tdata[LEVEL_W*(k+1) +: LEVEL_W];
            end
        end
    end

    // Result packing
    logic [SMP_W-1:0] slot_level [OUT_SLOTS];
    logic [EN_W-1:0]  slot_en;
    always_comb begin
        slot_en = '0;
        for (int s = 0; s < OUT_SLOTS; s++) begin
            slot_level[s] = '0;
            if (s < NUM_VOICES) begin
                slot_level[s] = last_reg[s];
                slot_en[s]    = on_reg[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({period_reg, slot_en,
                                       slot_level[2], slot_level[1], slot_level[0]});
        end
    end

    // Assertion helpers
    logic on_without_volume;
    always_comb begin
        on_without_volume = 1'b0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (on_reg[v] && (vol_reg[v] == '0)) on_without_volume = 1'b1;
        end
    end

    `include "keyed_wavetable_voice_synth_top_assert.svh"

    `KWVS_ASSERT_NXT(a_busy_after_accept, in_accept, !s_tready, "ready stayed high after accept")
    `KWVS_ASSERT_IMP(a_cal_order, 1'b1, cal_min_reg[0] <= cal_max_reg[0], "calibration inverted")
    `KWVS_ASSERT_IMP(a_on_has_volume, 1'b1, !on_without_volume, "voice on with zero volume")
    `KWVS_ASSERT_IMP(a_done_in_wait, div_rsp.done, state_reg == ST_WAIT, "divider done unexpected")
    `KWVS_ASSERT_IMP(a_claims_bounded, 1'b1, vsel_reg <= USED_W'(NUM_VOICES), "voice count overrun")

endmodule

[dv/tb_keyed_wavetable_voice_synth_top.sv]
// Self-checking testbench for keyed_wavetable_voice_synth_top: scan/tick stimulus over the
// stream ports, threshold programming over APB, results checked against an in-bench voice model.
// Depends on kwvs_pkg (port widths) and the synth RTL.
`timescale 1ns / 1ps

module tb_keyed_wavetable_voice_synth_top;

    import kwvs_pkg::*;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SCAN = 1'b1
    } opcode_e;

    // One result transaction, unpacked
    typedef struct packed {
        logic [3:0] level_a;
        logic [3:0] level_b;
        logic [3:0] level_c;
        logic [2:0] voice_enable;
        logic [7:0] sample_period;
    } synth_frame_t;

    // Directed row: keys hold key 4 in the top byte, key 0 in the bottom byte
    typedef struct packed {
        opcode_e      op;
        logic [7:0]   pitch;
        logic [39:0]  keys;
        logic         typed;
        synth_frame_t want;
    } stim_row_t;

    localparam logic [APB_AW-1:0] ADDR_ACTIVE_THRESHOLD = 'd0;

    localparam int VOICE_CNT    = 3;
    localparam int SCAN_KEYS    = 5;
    localparam int WAVE_CNT     = 5;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 150;

    localparam logic [3:0] WAVE_TABLE [0:118] = '{
        4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5,
        4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13, 4'd14, 4'd14, 4'd14, 4'd14,
        4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6,
        4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11,
        4'd12, 4'd12, 4'd13, 4'd13, 4'd14, 4'd14, 4'd15,
        4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd6,
        4'd7, 4'd7, 4'd8, 4'd9, 4'd9, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12,
        4'd13, 4'd14, 4'd14, 4'd15,
        4'd1, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd6, 4'd7, 4'd8,
        4'd9, 4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };
    localparam int WAVE_START [0:4] = '{0, 30, 57, 81, 101};
    localparam int WAVE_SPAN  [0:4] = '{30, 27, 24, 20, 18};

    // Directed stimulus; expected values typed in only for the obvious rows
    localparam stim_row_t DIRECTED_ROWS [0:22] = '{
        // tick straight out of reset: silence, reset period
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b1, '{4'd0, 4'd0, 4'd0, 3'd0, 8'd250}},
        // pitch above max clamps; key volume equal to threshold claims nothing
        '{OP_SCAN, 8'd255, {5{8'd130}}, 1'b1, '{4'd0, 4'd0, 4'd0, 3'd0, 8'd124}},
        // pitch below min clamps; full keys take all three voices
        '{OP_SCAN, 8'd0,   {5{8'd255}}, 1'b1, '{4'd0, 4'd0, 4'd0, 3'd7, 8'd125}},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        '{OP_TICK, 8'hFF,  {5{8'hFF}},  1'b0, '0},
        // keys 1, 3, 4 claim voices in key order, every note changes
        '{OP_SCAN, 8'd255, {8'd255, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        // all keys released: voices silenced, notes and positions kept
        '{OP_SCAN, 8'd128, {5{8'd0}},   1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        // same keys again: positions carry on
        '{OP_SCAN, 8'd64,  {8'd255, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        // key 0 just at threshold, key 1 just above, voice C left unused
        '{OP_SCAN, 8'd192, {8'd0, 8'd0, 8'd255, 8'd144, 8'd128}, 1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        '{OP_SCAN, 8'd0,   {5{8'd255}}, 1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        '{OP_SCAN, 8'hAA,  {8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        '{OP_SCAN, 8'h55,  {8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0},
        '{OP_TICK, 8'd0,   {5{8'd0}},   1'b0, '0}
    };

    localparam logic [4:0] PHASE_THR   [0:4] = '{5'd0, 5'd16, 5'd31, 5'd5, 5'd12};
    localparam int         PHASE_ITEMS [0:4] = '{400, 120, 60, 460, 460};

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_AW-1:0]       paddr    = '0;
    logic [APB_DW-1:0]       pwdata   = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // [7:0] pitch_level, [15:8] key_level_0 ... [47:40] key_level_4
    logic [S_TDATA_W-1:0]    s_tdata  = '0;
    // [0] opcode
    logic [0:0]              s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [3:0] level_a, [7:4] level_b, [11:8] level_c, [14:12] voice_enable,
    // [22:15] sample_period, [23] zero
    logic [M_TDATA_W-1:0]    m_tdata;

    // Voice model state
    logic [2:0] note_of    [VOICE_CNT];
    logic [4:0] phase_of   [VOICE_CNT];
    logic [4:0] gain_of    [VOICE_CNT];
    logic       is_on      [VOICE_CNT];
    logic [3:0] held_level [VOICE_CNT];
    logic [7:0] key_hi     [SCAN_KEYS];
    logic [7:0] key_lo     [SCAN_KEYS];
    logic [7:0] reload_val;
    logic [4:0] claim_thr;

    synth_frame_t frames_due [$];
    int           mismatches  = 0;
    int           quiet_cycles = 0;
    bit           sender_steady = 1'b0;
    bit           hold_wanted   = 1'b0;

    keyed_wavetable_voice_synth_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Integer rescale of a reading within [lo, hi]; zero span gives 0
    function automatic int unsigned rescale(int unsigned val, int unsigned lo,
                                            int unsigned hi, int unsigned mul);
        int unsigned span;
        int unsigned off;
        span = (hi > lo) ? hi - lo : 0;
        off  = (val > lo) ? val - lo : 0;
        return (span != 0) ? (off * mul) / span : 0;
    endfunction

    // Apply one transaction to the voice model and return the frame it produces
    function automatic synth_frame_t advance_synth(opcode_e op, logic [7:0] pitch,
                                                   logic [39:0] keys);
        synth_frame_t f;
        int unsigned  p;
        int unsigned  lv;
        int unsigned  vol;
        int unsigned  pos;
        int unsigned  lvl;
        int           n;
        int           claimed;
        f = '0;
        claimed = 0;
        if (op == OP_SCAN) begin
            // period uses key 0's calibration before key 0 widens it
            p = pitch;
            if (p < key_lo[0]) p = key_lo[0];
            if (p > key_hi[0]) p = key_hi[0];
            reload_val = 8'(rescale(p, key_lo[0], key_hi[0], 255) + 125);
            for (int k = 0; k < SCAN_KEYS; k++) begin
                lv = keys[8*k +: 8];
                if (lv > key_hi[k]) key_hi[k] = 8'(lv);
                if (lv < key_lo[k]) key_lo[k] = 8'(lv);
                vol = rescale(lv, key_lo[k], key_hi[k], 16);
                if (vol > claim_thr && claimed < VOICE_CNT) begin
                    // a new note restarts the wave
                    if (note_of[claimed] != 3'(k)) begin
                        note_of[claimed]  = 3'(k);
                        phase_of[claimed] = '0;
                    end
                    gain_of[claimed] = 5'(vol);
                    is_on[claimed]   = 1'b1;
                    claimed++;
                end
            end
            for (int v = claimed; v < VOICE_CNT; v++) begin
                is_on[v]   = 1'b0;
                gain_of[v] = '0;
            end
        end else begin
            for (int v = 0; v < VOICE_CNT; v++) begin
                lvl = 0;
                n   = note_of[v];
                if (gain_of[v] != 0 && n < WAVE_CNT) begin
                    pos = phase_of[v] + 1;
                    if (pos >= WAVE_SPAN[n]) pos = 0;
                    phase_of[v] = 5'(pos);
                    lvl = (WAVE_TABLE[WAVE_START[n] + pos] * gain_of[v]) >> 4;
                end
                held_level[v] = 4'(lvl);
            end
        end
        f.level_a       = held_level[0];
        f.level_b       = held_level[1];
        f.level_c       = held_level[2];
        f.voice_enable  = {is_on[2], is_on[1], is_on[0]};
        f.sample_period = reload_val;
        return f;
    endfunction

    function automatic void report(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
            report($sformatf("%s mismatch: expected %0d, actual %0d", name, want, got));
    endfunction

    // Mostly short gaps, a few long ones, none while in a steady stretch
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Readings biased toward the rails so calibration and clamps get exercised
    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the threshold, mirror it in the model, read it back
    task automatic program_threshold(input logic [4:0] thr);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, ADDR_ACTIVE_THRESHOLD, APB_DW'(thr), rd);
        claim_thr = thr;
        @(posedge aclk);
        apb_access(1'b0, ADDR_ACTIVE_THRESHOLD, '0, rd);
        check_field("active_threshold readback", thr, rd);
    endtask

    // Offer one transaction, wait for it to be taken, queue its expected frame
    task automatic play_item(input opcode_e op, input logic [7:0] pitch, input logic [39:0] keys,
                             input logic typed, input synth_frame_t want);
        int           gap;
        synth_frame_t frame;
        gap = pick_gap(sender_steady);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {keys, pitch};
        do @(posedge aclk); while (!s_tready);
        frame = advance_synth(op, pitch, keys);
        frames_due.push_back(typed ? want : frame);
    endtask

    // Result checker and stall counter
    always @(posedge aclk) begin
        synth_frame_t want;
        synth_frame_t got;
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[3:0], m_tdata[7:4], m_tdata[11:8], m_tdata[14:12],
                        m_tdata[22:15]};
                if (frames_due.size() == 0) begin
                    report($sformatf("result with none outstanding: tdata 0x%06h", m_tdata));
                end else begin
                    want = frames_due.pop_front();
                    check_field("level_a", want.level_a, got.level_a);
                    check_field("level_b", want.level_b, got.level_b);
                    check_field("level_c", want.level_c, got.level_c);
                    check_field("voice_enable", want.voice_enable, got.voice_enable);
                    check_field("sample_period", want.sample_period, got.sample_period);
                end
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 7) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                gap = pick_gap(1'b0);
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: no transaction on either stream for too long
    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        opcode_e     op;
        logic [7:0]  pitch;
        logic [39:0] keys;
        logic [4:0]  thr;

        // model back to its reset state
        for (int v = 0; v < VOICE_CNT; v++) begin
            note_of[v]    = 3'd5;
            phase_of[v]   = '0;
            gain_of[v]    = '0;
            is_on[v]      = 1'b0;
            held_level[v] = '0;
        end
        for (int k = 0; k < SCAN_KEYS; k++) begin
            key_hi[k] = 8'd200;
            key_lo[k] = 8'd60;
        end
        reload_val = 8'd250;
        claim_thr  = 5'd8;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows run at the reset threshold
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            play_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].pitch, DIRECTED_ROWS[i].keys,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // random phases, threshold changed only once the block has drained
        for (int ph = 0; ph < $size(PHASE_THR); ph++) begin
            s_tvalid <= 1'b0;
            while (frames_due.size() != 0) @(posedge aclk);
            thr = (ph == 3) ? 5'($urandom_range(1, 15)) : PHASE_THR[ph];
            program_threshold(thr);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
                if (n % 64 == 0) sender_steady = ($urandom_range(0, 4) == 0);
                if (ph == 0 && n == 100) hold_wanted = 1'b1;
                op    = ($urandom_range(0, 3) == 0) ? OP_SCAN : OP_TICK;
                pitch = pick_level();
                for (int k = 0; k < SCAN_KEYS; k++) keys[8*k +: 8] = pick_level();
                play_item(op, pitch, keys, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (frames_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
